>>> src/cpbo_pkg.sv
package cpbo_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordWidth  = 16;
  localparam int AxisWidth   = CoordWidth + 1;
  localparam int ProdWidth   = CoordWidth + AxisWidth;
  localparam int ProjWidth   = ProdWidth + 1;
  localparam int IdxWidth    = $clog2(MaxVertices);
  localparam int CntWidth    = $clog2(MaxVertices + 1);
  localparam int StepWidth   = $clog2(MaxVertices + 2);

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_TEST   = 1'b1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [AxisWidth-1:0]  axis_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [ProjWidth-1:0]  proj_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TAG_BOX_LO = 2'd0,
    TAG_BOX_HI = 2'd1,
    TAG_FIRST  = 2'd2,
    TAG_NEXT   = 2'd3
  } proj_tag_t;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_EDGE = 2'd2
  } axis_sel_t;

  typedef struct packed {
    logic      valid;
    proj_tag_t tag;
    coord_t    x;
    coord_t    y;
  } proj_pt_t;

  typedef struct packed {
    logic  busy;
    proj_t plo;
    proj_t phi;
    proj_t blo;
    proj_t bhi;
  } proj_res_t;

endpackage

>>> src/cpbo_vtx_mem.sv
module cpbo_vtx_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [cpbo_pkg::IdxWidth-1:0]   waddr,
  input  cpbo_pkg::coord_t                wx,
  input  cpbo_pkg::coord_t                wy,
  input  logic [cpbo_pkg::IdxWidth-1:0]   raddr,
  output cpbo_pkg::coord_t                rx,
  output cpbo_pkg::coord_t                ry
);

  cpbo_pkg::coord_t mem_x [cpbo_pkg::MaxVertices];
  cpbo_pkg::coord_t mem_y [cpbo_pkg::MaxVertices];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

>>> src/cpbo_proj.sv
module cpbo_proj (
  input  logic                  clk,
  input  logic                  rst,
  input  cpbo_pkg::proj_pt_t    pt,
  input  cpbo_pkg::axis_t       ax,
  input  cpbo_pkg::axis_t       ay,
  output cpbo_pkg::proj_res_t   res
);

  logic                 pv;
  cpbo_pkg::proj_tag_t  ptag;
  cpbo_pkg::prod_t      prod_x;
  cpbo_pkg::prod_t      prod_y;
  cpbo_pkg::proj_t      sum;
  cpbo_pkg::proj_t      plo;
  cpbo_pkg::proj_t      phi;
  cpbo_pkg::proj_t      blo;
  cpbo_pkg::proj_t      bhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    ptag   <= pt.tag;
    prod_x <= pt.x * ax;
    prod_y <= pt.y * ay;
  end

  assign sum = cpbo_pkg::ProjWidth'(prod_x) + cpbo_pkg::ProjWidth'(prod_y);

  always_ff @(posedge clk) begin
    if (pv) begin
      case (ptag)
        cpbo_pkg::TAG_BOX_LO: blo <= sum;
        cpbo_pkg::TAG_BOX_HI: bhi <= sum;
        cpbo_pkg::TAG_FIRST: begin
          plo <= sum;
          phi <= sum;
        end
        cpbo_pkg::TAG_NEXT: begin
          if (sum < plo) plo <= sum;
          if (sum > phi) phi <= sum;
        end
        default: ;
      endcase
    end
  end

  assign res.busy = pv;
  assign res.plo  = plo;
  assign res.phi  = phi;
  assign res.blo  = blo;
  assign res.bhi  = bhi;

endmodule

>>> src/convex_polygon_box_overlap_test.sv
// Channel  Handshake             Payload
// input    in_valid / in_ready   command, new_polygon, px, py, qx, qy
// output   out_valid / out_ready intersects, status
//
// Append: the vertex is written from idle, and the block stays ready for more input.
// Test: x, y, then edge normals, one vertex projection a cycle per axis.
// Empty polygon: reported empty without projection. One item is worked on at a time.
// Reset clears vertex count, dropped flag and control; the vertex memory is not cleared.
// A held result stalls only the end of the next test.
module convex_polygon_box_overlap_test (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic                   new_polygon,
  input  cpbo_pkg::coord_t       px,
  input  cpbo_pkg::coord_t       py,
  input  cpbo_pkg::coord_t       qx,
  input  cpbo_pkg::coord_t       qy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   intersects,
  output logic [1:0]             status
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WALK  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_EA    = 8'b0001_0000,
    S_EB    = 8'b0010_0000,
    S_EC    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                              state;
  logic [cpbo_pkg::CntWidth-1:0]       count;
  logic                                dropped;
  cpbo_pkg::coord_t                    xmin, xmax, ymin, ymax;
  cpbo_pkg::axis_t                     ax, ay;
  cpbo_pkg::axis_sel_t                 axis_sel;
  logic [cpbo_pkg::IdxWidth-1:0]       edge_idx;
  logic [cpbo_pkg::StepWidth-1:0]      step;
  cpbo_pkg::coord_t                    vix, viy;
  logic                                res_hit;
  cpbo_pkg::status_t                   res_status;
  logic                                out_hit;
  cpbo_pkg::status_t                   out_status;

  logic                                s1_valid;
  cpbo_pkg::proj_tag_t                 s1_tag;
  logic                                s1_corner;
  cpbo_pkg::coord_t                    s1_cx, s1_cy;

  logic                                in_fire;
  logic                                we;
  logic [cpbo_pkg::IdxWidth-1:0]       waddr;
  logic [cpbo_pkg::IdxWidth-1:0]       raddr;
  cpbo_pkg::coord_t                    rx, ry;
  logic                                edge_last;
  logic [cpbo_pkg::IdxWidth-1:0]       edge_nxt;
  cpbo_pkg::axis_t                     ex, ey;
  logic                                separated;
  logic                                out_free;
  cpbo_pkg::proj_pt_t                  pt;
  cpbo_pkg::proj_res_t                 pres;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign we    = in_fire && (command == cpbo_pkg::CMD_APPEND) &&
                 (new_polygon || (count < cpbo_pkg::CntWidth'(cpbo_pkg::MaxVertices)));
  assign waddr = new_polygon ? '0 : count[cpbo_pkg::IdxWidth-1:0];

  assign edge_last = (cpbo_pkg::CntWidth'(edge_idx) + cpbo_pkg::CntWidth'(1)) == count;
  assign edge_nxt  = edge_last ? '0 : edge_idx + cpbo_pkg::IdxWidth'(1);

  assign ex = cpbo_pkg::AxisWidth'(rx) - cpbo_pkg::AxisWidth'(vix);
  assign ey = cpbo_pkg::AxisWidth'(ry) - cpbo_pkg::AxisWidth'(viy);

  assign separated = (pres.phi <= pres.blo) || (pres.bhi <= pres.plo);

  always_comb begin
    case (state)
      S_EA:    raddr = edge_idx;
      S_EB:    raddr = edge_nxt;
      default: raddr = cpbo_pkg::IdxWidth'(step - cpbo_pkg::StepWidth'(2));
    endcase
  end

  cpbo_vtx_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wx    (px),
    .wy    (py),
    .raddr (raddr),
    .rx    (rx),
    .ry    (ry)
  );

  assign pt.valid = s1_valid;
  assign pt.tag   = s1_tag;
  assign pt.x     = s1_corner ? s1_cx : rx;
  assign pt.y     = s1_corner ? s1_cy : ry;

  cpbo_proj u_proj (
    .clk (clk),
    .rst (rst),
    .pt  (pt),
    .ax  (ax),
    .ay  (ay),
    .res (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (command == cpbo_pkg::CMD_APPEND) begin
              if (we) begin
                count   <= cpbo_pkg::CntWidth'(waddr) + cpbo_pkg::CntWidth'(1);
                dropped <= new_polygon ? 1'b0 : dropped;
              end else begin
                dropped <= 1'b1;
              end
            end else if (count == '0) begin
              res_hit    <= 1'b0;
              res_status <= cpbo_pkg::STATUS_EMPTY;
              state      <= S_DONE;
            end else begin
              xmin       <= (px < qx) ? px : qx;
              xmax       <= (px < qx) ? qx : px;
              ymin       <= (py < qy) ? py : qy;
              ymax       <= (py < qy) ? qy : py;
              ax         <= cpbo_pkg::AxisWidth'(1);
              ay         <= '0;
              axis_sel   <= cpbo_pkg::AXIS_X;
              step       <= '0;
              res_status <= dropped ? cpbo_pkg::STATUS_DROPPED : cpbo_pkg::STATUS_OK;
              state      <= S_WALK;
            end
          end
        end
        S_WALK: begin
          s1_valid  <= 1'b1;
          s1_corner <= (step < cpbo_pkg::StepWidth'(2));
          if (step == '0) begin
            s1_tag <= cpbo_pkg::TAG_BOX_LO;
            s1_cx  <= ax[cpbo_pkg::AxisWidth-1] ? xmax : xmin;
            s1_cy  <= ay[cpbo_pkg::AxisWidth-1] ? ymax : ymin;
          end else if (step == cpbo_pkg::StepWidth'(1)) begin
            s1_tag <= cpbo_pkg::TAG_BOX_HI;
            s1_cx  <= ax[cpbo_pkg::AxisWidth-1] ? xmin : xmax;
            s1_cy  <= ay[cpbo_pkg::AxisWidth-1] ? ymin : ymax;
          end else if (step == cpbo_pkg::StepWidth'(2)) begin
            s1_tag <= cpbo_pkg::TAG_FIRST;
          end else begin
            s1_tag <= cpbo_pkg::TAG_NEXT;
          end
          step <= step + cpbo_pkg::StepWidth'(1);
          if (step == cpbo_pkg::StepWidth'(count) + cpbo_pkg::StepWidth'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !pres.busy) state <= S_CHECK;
        end
        S_CHECK: begin
          step <= '0;
          if (separated) begin
            res_hit <= 1'b0;
            state   <= S_DONE;
          end else begin
            case (axis_sel)
              cpbo_pkg::AXIS_X: begin
                ax       <= '0;
                ay       <= cpbo_pkg::AxisWidth'(1);
                axis_sel <= cpbo_pkg::AXIS_Y;
                state    <= S_WALK;
              end
              cpbo_pkg::AXIS_Y: begin
                axis_sel <= cpbo_pkg::AXIS_EDGE;
                edge_idx <= '0;
                state    <= S_EA;
              end
              default: begin
                if (edge_last) begin
                  res_hit <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  edge_idx <= edge_nxt;
                  state    <= S_EA;
                end
              end
            endcase
          end
        end
        S_EA: state <= S_EB;
        S_EB: begin
          vix   <= rx;
          viy   <= ry;
          state <= S_EC;
        end
        S_EC: begin
          if (ex == '0 && ey == '0) begin
            if (edge_last) begin
              res_hit <= 1'b1;
              state   <= S_DONE;
            end else begin
              edge_idx <= edge_nxt;
              state    <= S_EA;
            end
          end else begin
            ax    <= -ey;
            ay    <= ex;
            step  <= '0;
            state <= S_WALK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_hit    <= res_hit;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign intersects = out_hit;
  assign status     = out_status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cpbo_pkg::CntWidth'(cpbo_pkg::MaxVertices))
    else $error("vertex count beyond capacity");

  a_dropped_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> count == cpbo_pkg::CntWidth'(cpbo_pkg::MaxVertices))
    else $error("dropped flag set with room left");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !s1_valid && !pres.busy)
    else $error("projection pipe busy while idle");

  a_empty_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cpbo_pkg::STATUS_EMPTY |-> !intersects)
    else $error("empty polygon reported as overlapping");

endmodule
